>>> rtl/timer_prescaler_reload_solver_unit_defines.svh
// assertion helpers for the timer prescaler solver
`ifndef TIMER_PRESCALER_RELOAD_SOLVER_UNIT_DEFINES_SVH
`define TIMER_PRESCALER_RELOAD_SOLVER_UNIT_DEFINES_SVH

// same-cycle implication, checked on clk with reset held off
`define TPRS_ASSERT_NOW(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("tprs assertion failed");

// next-cycle implication
`define TPRS_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("tprs assertion failed");

`endif

>>> rtl/tprs_pkg.sv
package tprs_pkg;
	localparam int CLK_W = 28;
	localparam int HZ_IN_W = 32;
	localparam int HZ_W = 18;
	localparam int FIELD_W = 16;
	localparam int XW = 34;
	localparam int CMP_DEN_W = 4;
	localparam int COUNTER_WIDTH_DEF = 16;
	localparam logic [HZ_W-1:0] HZ_MIN = 18'd10;
	localparam logic [HZ_W-1:0] HZ_MAX = 18'd200000;
	localparam logic [CLK_W-1:0] CLK_RESET = 28'd108000000;
	localparam logic [CMP_DEN_W-1:0] COMPARE_DIV = 4'd10;
endpackage

>>> rtl/tprs_div_pipe.sv
module tprs_div_pipe #(
	parameter int NW = 28,
	parameter int DW = 18,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic [SW-1:0] side,
	output logic          out_valid,
	output logic [NW-1:0] quo,
	output logic [SW-1:0] out_side
);
	// one quotient bit per stage, restoring division
	logic [NW-1:0] num_s   [NW];
	logic [NW-1:0] quo_s   [NW];
	logic [DW-1:0] den_s   [NW];
	logic [DW-1:0] rem_s   [NW];
	logic [SW-1:0] side_s  [NW];
	logic          valid_s [NW];

	for (genvar k = 0; k < NW; k++) begin : g_stage
		logic [NW-1:0] p_num;
		logic [NW-1:0] p_quo;
		logic [DW-1:0] p_den;
		logic [DW-1:0] p_rem;
		logic [SW-1:0] p_side;
		logic          p_valid;
		logic [DW:0]   trial;
		logic [DW:0]   diff;
		logic          ge;

		if (k == 0) begin : g_first
			assign p_num = num;
			assign p_quo = '0;
			assign p_den = den;
			assign p_rem = '0;
			assign p_side = side;
			assign p_valid = in_valid;
		end else begin : g_next
			assign p_num = num_s[k-1];
			assign p_quo = quo_s[k-1];
			assign p_den = den_s[k-1];
			assign p_rem = rem_s[k-1];
			assign p_side = side_s[k-1];
			assign p_valid = valid_s[k-1];
		end

		assign trial = {p_rem, p_num[NW-1]};
		assign ge = trial >= {1'b0, p_den};
		assign diff = trial - {1'b0, p_den};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else if (en) begin
				valid_s[k] <= p_valid;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				num_s[k] <= {p_num[NW-2:0], 1'b0};
				quo_s[k] <= {p_quo[NW-2:0], ge};
				den_s[k] <= p_den;
				rem_s[k] <= ge ? diff[DW-1:0] : trial[DW-1:0];
				side_s[k] <= p_side;
			end
		end
	end

	assign out_valid = valid_s[NW-1];
	assign quo = quo_s[NW-1];
	assign out_side = side_s[NW-1];
endmodule

>>> rtl/timer_prescaler_reload_solver_unit.sv
// timer prescaler / auto-reload solver
// input channel: in_valid, in_stall, requested_hz. each request is a timer
// update frequency, clamped inside to 10..200000 hz.
// output channel: out_valid, out_stall, prescaler, reload, compare,
// clock_error. one result per request, in request order.
// config channel: cfg_valid, cfg_ready, cfg_data write the timer kernel
// clock in hz; cfg_ready is always high. write only while idle.
// the pipeline at any COUNTER_WIDTH is two 28-stage dividers (ticks
// per period, then reload) and five registers around them (input, between
// the dividers, reload clamp, compare multiply, output).
// throughput is one request per cycle unless out_stall holds the pipeline; every stage holds one request.
// reset clears all valid bits and loads the clock register with 108 mhz.
// when out_valid is high and out_stall is high the whole pipeline holds,
// in_stall rises, and nothing is lost or repeated.
// a zero timer clock gives clock_error with all values zero.
module timer_prescaler_reload_solver_unit #(
	parameter int COUNTER_WIDTH = tprs_pkg::COUNTER_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [tprs_pkg::CLK_W-1:0]   cfg_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [tprs_pkg::HZ_IN_W-1:0] requested_hz,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [tprs_pkg::FIELD_W-1:0] prescaler,
	output logic [tprs_pkg::FIELD_W-1:0] reload,
	output logic [tprs_pkg::FIELD_W-1:0] compare,
	output logic                         clock_error
);
	import tprs_pkg::*;
	`include "timer_prescaler_reload_solver_unit_defines.svh"

	localparam int W = COUNTER_WIDTH;
	localparam logic [XW-1:0] SPAN = XW'(1) << W;
	// divide by ten as multiply by a rounded-up reciprocal, exact for per <= 2^W
	localparam int CMP_SH = W + 4;
	localparam longint unsigned CMP_MUL_L =
		((64'd1 << CMP_SH) + 64'(COMPARE_DIV) - 64'd1) / 64'(COMPARE_DIV);
	localparam logic [W:0] CMP_MUL = CMP_MUL_L[W:0];

	logic en;
	logic [CLK_W-1:0] clk_hz_q;

	logic             valid_s1;
	logic [HZ_W-1:0]  hz_s1;
	logic [CLK_W-1:0] clk_s1;
	logic             err_s1;

	logic             d1_valid;
	logic [CLK_W-1:0] d1_quo;
	logic             d1_err;

	logic             valid_s2;
	logic [CLK_W-1:0] ticks_s2;
	logic [W:0]       den_s2;
	logic [W-1:0]     psc_s2;
	logic             err_s2;

	logic             d2_valid;
	logic [CLK_W-1:0] d2_quo;
	logic [W:0]       d2_side;

	logic             valid_s3;
	logic [W:0]       per_s3;
	logic [W-1:0]     arr_s3;
	logic [W-1:0]     psc_s3;
	logic             err_s3;

	logic             valid_s4;
	logic [2*W+1:0]   prod_s4;
	logic [W-1:0]     arr_s4;
	logic [W-1:0]     psc_s4;
	logic             err_s4;

	logic [FIELD_W-1:0] psc_s5;
	logic [FIELD_W-1:0] arr_s5;
	logic [FIELD_W-1:0] ccr_s5;
	logic               err_s5;
	logic               valid_s5;

	logic [HZ_W-1:0] hz_c;
	logic [XW-1:0]   tk;
	logic [XW-1:0]   psc_raw;
	logic [XW-1:0]   psc_c;
	logic [XW-1:0]   arr_x;
	logic [XW-1:0]   per_c;
	logic [XW-1:0]   ccr_x;
	logic [XW-1:0]   arr_m1_x;

	// one global advance: the last register is the output register
	assign en = !valid_s5 || !out_stall;
	assign in_stall = !en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clk_hz_q <= CLK_RESET;
		end else if (cfg_valid) begin
			clk_hz_q <= cfg_data;
		end
	end

	always_comb begin
		if (requested_hz < HZ_IN_W'(HZ_MIN)) begin
			hz_c = HZ_MIN;
		end else if (requested_hz > HZ_IN_W'(HZ_MAX)) begin
			hz_c = HZ_MAX;
		end else begin
			hz_c = requested_hz[HZ_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= d1_valid;
			valid_s3 <= d2_valid;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hz_s1 <= hz_c;
			clk_s1 <= clk_hz_q;
			err_s1 <= clk_hz_q == '0;
		end
	end

	tprs_div_pipe #(.NW(CLK_W), .DW(HZ_W), .SW(1)) u_ticks_div (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(valid_s1), .num(clk_s1), .den(hz_s1), .side(err_s1),
		.out_valid(d1_valid), .quo(d1_quo), .out_side(d1_err)
	);

	// prescaler = ceil(ticks / span) - 1, saturated
	always_comb begin
		tk = (d1_quo < CLK_W'(2)) ? XW'(2) : XW'(d1_quo);
		psc_raw = (tk - XW'(1)) >> W;
		psc_c = (psc_raw > SPAN - XW'(1)) ? SPAN - XW'(1) : psc_raw;
	end

	// ticks + prescaler so the reload divide rounds up
	always_ff @(posedge clk) begin
		if (en) begin
			ticks_s2 <= CLK_W'(tk + psc_c);
			psc_s2 <= psc_c[W-1:0];
			den_s2 <= (W+1)'(psc_c + XW'(1));
			err_s2 <= d1_err;
		end
	end

	tprs_div_pipe #(.NW(CLK_W), .DW(W+1), .SW(W+1)) u_reload_div (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(valid_s2), .num(ticks_s2), .den(den_s2), .side({err_s2, psc_s2}),
		.out_valid(d2_valid), .quo(d2_quo), .out_side(d2_side)
	);

	always_comb begin
		arr_x = XW'(d2_quo);
		if (arr_x == '0) begin
			per_c = XW'(1);
		end else if (arr_x > SPAN) begin
			per_c = SPAN;
		end else begin
			per_c = arr_x;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			per_s3 <= per_c[W:0];
			arr_s3 <= W'(per_c - XW'(1));
			psc_s3 <= d2_side[W-1:0];
			err_s3 <= d2_side[W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s4 <= (2*W+2)'(per_s3) * (2*W+2)'(CMP_MUL);
			arr_s4 <= arr_s3;
			psc_s4 <= psc_s3;
			err_s4 <= err_s3;
		end
	end

	always_comb begin
		arr_m1_x = XW'(arr_s4);
		ccr_x = (prod_s4[2*W+1:CMP_SH] == '0) ? XW'(1) : XW'(prod_s4[2*W+1:CMP_SH]);
		if (ccr_x > arr_m1_x) begin
			ccr_x = arr_m1_x;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			err_s5 <= err_s4;
			psc_s5 <= err_s4 ? '0 : FIELD_W'(psc_s4);
			arr_s5 <= err_s4 ? '0 : FIELD_W'(arr_m1_x);
			ccr_s5 <= err_s4 ? '0 : FIELD_W'(ccr_x);
		end
	end

	assign out_valid = valid_s5;
	assign prescaler = psc_s5;
	assign reload = arr_s5;
	assign compare = ccr_s5;
	assign clock_error = err_s5;

	`TPRS_ASSERT_NOW(a_err_zero, out_valid && clock_error,
		prescaler == '0 && reload == '0 && compare == '0)
	`TPRS_ASSERT_NOW(a_stall_src, in_stall, out_valid && out_stall)
	`TPRS_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid)
endmodule
